@@ design/ctd_pkg.sv @@
// Package for the chord template detector: payload types, MIDI codes and helpers.
`default_nettype none

package ctd_pkg;

  localparam int unsigned NumPitchClasses = 12;
  localparam int unsigned NumTemplates    = 2 * NumPitchClasses;

  localparam logic [7:0] STATUS_NOTE_ON  = 8'd144;
  localparam logic [7:0] STATUS_NOTE_OFF = 8'd128;
  localparam logic signed [3:0] NO_CHORD = -4'sd6;

  // Template score: three for the root, one each for third and fifth.
  typedef logic [2:0] score_t;
  typedef logic [4:0] tmpl_idx_t;
  typedef logic [3:0] pitch_class_t;

  typedef struct packed {
    logic [6:0] note_number;
    logic [7:0] status_byte;
  } in_item_t;

  typedef struct packed {
    logic signed [3:0] chord_root;
    logic              is_minor;
    logic              minor_written;
  } out_item_t;

  // Pitch class of a MIDI note: restoring reduction by 96, 48, 24 and 12.
  function automatic pitch_class_t pitch_class(input logic [6:0] note);
    logic [6:0] v;
    v = note;
    if (v >= 7'd96) v = v - 7'd96;
    if (v >= 7'd48) v = v - 7'd48;
    if (v >= 7'd24) v = v - 7'd24;
    if (v >= 7'd12) v = v - 7'd12;
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

@@ design/chord_template_detector.sv @@
// Chord template detector: held pitch-class mask and best-triad selection per MIDI event.
//
//   channel | direction | payload     | handshake
//   --------+-----------+-------------+--------------------
//   in_     | input     | in_item_t   | in_valid / in_stall
//   out_    | output    | out_item_t  | out_valid / out_stall
//
// One event per cycle sustained while out_stall is low; a result passes through the input
// stage and the result register before it can transfer out.
// The mask is updated in the input stage; the 24 template scores and a registered-free
// five-level argmax tree sit between the input stage and the result register.
// Synchronous active-low reset clears the mask and both valid flags.
// A stalled result holds the result register; the input stage then stalls only if it
// is also full, so one new event can still be taken while a result waits.
`default_nettype none

module chord_template_detector (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ctd_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ctd_pkg::out_item_t      out_data
);
  import ctd_pkg::*;

  // Pipeline control.
  logic        s1_valid_r;
  logic        s1_note_off_r;
  logic [11:0] mask_r;
  logic [11:0] mask_nxt;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   out_data_nxt;
  logic        advance;
  logic        in_accept;
  pitch_class_t in_pc;

  assign advance   = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;
  assign in_pc     = pitch_class(in_data.note_number);

  // Set the bit on note on, clear it for every other status.
  always_comb begin
    mask_nxt = mask_r;
    if (in_data.status_byte == STATUS_NOTE_ON) begin
      mask_nxt[in_pc] = 1'b1;
    end else begin
      mask_nxt[in_pc] = 1'b0;
    end
  end

  // Template scores: major templates first, then minor.
  score_t    lvl0_s [NumTemplates];
  tmpl_idx_t lvl0_i [NumTemplates];
  always_comb begin
    for (int r = 0; r < NumPitchClasses; r++) begin
      lvl0_s[r] = {1'b0, mask_r[r], mask_r[r]} + {2'b00, mask_r[(r + 4) % NumPitchClasses]}
                  + {2'b00, mask_r[(r + 7) % NumPitchClasses]};
      lvl0_i[r] = tmpl_idx_t'(r);
      lvl0_s[r + NumPitchClasses] = {1'b0, mask_r[r], mask_r[r]}
                  + {2'b00, mask_r[(r + 3) % NumPitchClasses]}
                  + {2'b00, mask_r[(r + 7) % NumPitchClasses]};
      lvl0_i[r + NumPitchClasses] = tmpl_idx_t'(r + NumPitchClasses);
    end
  end

  // Argmax tree; the right side wins only on a strictly higher score,
  // which keeps the first maximum in template order.
  score_t    lvl1_s [12];
  tmpl_idx_t lvl1_i [12];
  score_t    lvl2_s [6];
  tmpl_idx_t lvl2_i [6];
  score_t    lvl3_s [3];
  tmpl_idx_t lvl3_i [3];
  score_t    lvl4_s;
  tmpl_idx_t lvl4_i;
  score_t    best_s;
  tmpl_idx_t best_i;
  always_comb begin
    for (int k = 0; k < 12; k++) begin
      if (lvl0_s[2*k+1] > lvl0_s[2*k]) begin
        lvl1_s[k] = lvl0_s[2*k+1];
        lvl1_i[k] = lvl0_i[2*k+1];
      end else begin
        lvl1_s[k] = lvl0_s[2*k];
        lvl1_i[k] = lvl0_i[2*k];
      end
    end
    for (int k = 0; k < 6; k++) begin
      if (lvl1_s[2*k+1] > lvl1_s[2*k]) begin
        lvl2_s[k] = lvl1_s[2*k+1];
        lvl2_i[k] = lvl1_i[2*k+1];
      end else begin
        lvl2_s[k] = lvl1_s[2*k];
        lvl2_i[k] = lvl1_i[2*k];
      end
    end
    for (int k = 0; k < 3; k++) begin
      if (lvl2_s[2*k+1] > lvl2_s[2*k]) begin
        lvl3_s[k] = lvl2_s[2*k+1];
        lvl3_i[k] = lvl2_i[2*k+1];
      end else begin
        lvl3_s[k] = lvl2_s[2*k];
        lvl3_i[k] = lvl2_i[2*k];
      end
    end
    if (lvl3_s[1] > lvl3_s[0]) begin
      lvl4_s = lvl3_s[1];
      lvl4_i = lvl3_i[1];
    end else begin
      lvl4_s = lvl3_s[0];
      lvl4_i = lvl3_i[0];
    end
    if (lvl3_s[2] > lvl4_s) begin
      best_s = lvl3_s[2];
      best_i = lvl3_i[2];
    end else begin
      best_s = lvl4_s;
      best_i = lvl4_i;
    end
  end

  // Result formatting: roots 7..11 fold to -5..-1 in four bits.
  logic [3:0] best_root;
  logic       best_minor;
  always_comb begin
    best_minor = (best_i >= tmpl_idx_t'(NumPitchClasses));
    best_root  = best_minor ? 4'(best_i - tmpl_idx_t'(NumPitchClasses)) : best_i[3:0];
    out_data_nxt.minor_written = 1'b1;
    out_data_nxt.is_minor      = best_minor;
    if (best_s == '0) begin
      out_data_nxt.chord_root = NO_CHORD;
    end else if (best_root <= 4'd6) begin
      out_data_nxt.chord_root = best_root;
    end else begin
      out_data_nxt.chord_root = best_root + 4'd4;
    end
    if (s1_note_off_r) begin
      out_data_nxt.chord_root    = NO_CHORD;
      out_data_nxt.is_minor      = 1'b0;
      out_data_nxt.minor_written = 1'b0;
    end
  end

  // Input stage and held-note mask.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      mask_r     <= '0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
      if (in_valid) begin
        mask_r <= mask_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_note_off_r <= (in_data.status_byte == STATUS_NOTE_OFF);
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A note-off result carries no chord and no minor decision.
  a_note_off_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.minor_written |->
      out_data_r.chord_root == NO_CHORD && !out_data_r.is_minor)
    else $error("note-off result has chord fields set");

  // A minor template can only win with a nonzero score.
  a_minor_has_root: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.is_minor |-> out_data_r.chord_root != NO_CHORD)
    else $error("minor result without a chord root");

  // The input side stalls only with a full input stage.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with an empty input stage");

  // A note-on transfer leaves its pitch class held.
  a_note_on_sets: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.status_byte == STATUS_NOTE_ON |=> mask_r[$past(in_pc)])
    else $error("note on did not set its pitch class");

  // A transfer with any other status clears its pitch class.
  a_other_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept && in_data.status_byte != STATUS_NOTE_ON |=> !mask_r[$past(in_pc)])
    else $error("release did not clear its pitch class");

endmodule

`default_nettype wire

@@ verif/chord_template_detector_tb.sv @@
// Testbench for the chord template detector: directed and random MIDI events vs. a predictor.
`default_nettype none

module chord_template_detector_tb;
  import ctd_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int MaxReported  = 10;
  localparam int RandomPerSet = 230;
  localparam int DrainCycles  = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  // Predictor state: pitch classes currently held.
  logic [NumPitchClasses-1:0] held_mask = '0;
  out_item_t chord_expect_q[$];

  int send_idle_pct  = 0;
  int recv_idle_pct  = 0;
  int hold_request   = 0;
  int hold_left      = 0;
  int cycle_count    = 0;
  int mismatch_count = 0;
  int events_sent    = 0;
  int results_seen   = 0;
  int note_on_count  = 0;
  int note_off_count = 0;
  int other_count    = 0;
  int triads_played  = 0;

  chord_template_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Run guard: give up well past the slowest legal run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               chord_expect_q.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Update the held mask with one event and work out the chord it reports.
  function automatic out_item_t predict_chord(input in_item_t ev);
    int pc;
    int t;
    int r;
    int score;
    int best;
    int best_idx;
    int root;
    out_item_t res;
    pc = int'(ev.note_number) % NumPitchClasses;
    held_mask[pc] = (ev.status_byte == STATUS_NOTE_ON);
    best = 0;
    best_idx = 0;
    for (t = 0; t < NumTemplates; t++) begin
      r = t % NumPitchClasses;
      score = 3 * int'(held_mask[r])
            + int'(held_mask[(r + ((t < NumPitchClasses) ? 4 : 3)) % NumPitchClasses])
            + int'(held_mask[(r + 7) % NumPitchClasses]);
      // Only a strictly higher score displaces the earlier template.
      if (t == 0 || score > best) begin
        best = score;
        best_idx = t;
      end
    end
    if (ev.status_byte == STATUS_NOTE_OFF) begin
      res.chord_root    = NO_CHORD;
      res.is_minor      = 1'b0;
      res.minor_written = 1'b0;
    end else begin
      r = best_idx % NumPitchClasses;
      if (best == 0) root = int'(NO_CHORD);
      else if (r <= 6) root = r;
      else root = r - NumPitchClasses;
      res.chord_root    = root[3:0];
      res.is_minor      = (best_idx >= NumPitchClasses);
      res.minor_written = 1'b1;
    end
    return res;
  endfunction

  // Offer one event, idling first at the current rate, and record its expected chord.
  task automatic send_event(input logic [6:0] note, input logic [7:0] status);
    in_item_t ev;
    ev.note_number = note;
    ev.status_byte = status;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= ev;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chord_expect_q.push_back(predict_chord(ev));
    events_sent++;
    if (status == STATUS_NOTE_ON) note_on_count++;
    else if (status == STATUS_NOTE_OFF) note_off_count++;
    else other_count++;
  endtask

  // Drop valid and wait until every expected chord has been returned.
  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (chord_expect_q.size() != 0) @(posedge clk);
  endtask

  // Receiver: forced hold-off when requested, otherwise random stall.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_mismatch(input bit unexpected, input out_item_t want,
                                 input out_item_t got);
    mismatch_count++;
    if (mismatch_count <= MaxReported) begin
      if (unexpected)
        $display("Cycle %0d: unexpected result root %0d minor %0b written %0b",
                 cycle_count, got.chord_root, got.is_minor, got.minor_written);
      else
        $display("Cycle %0d: expected %0d/%0b/%0b, got %0d/%0b/%0b (root/minor/written)",
                 cycle_count, want.chord_root, want.is_minor, want.minor_written,
                 got.chord_root, got.is_minor, got.minor_written);
    end
  endtask

  // Result checker: every transfer is compared with the oldest expected chord.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (chord_expect_q.size() == 0) begin
        report_mismatch(1'b1, '0, out_data);
      end else begin
        want = chord_expect_q.pop_front();
        if (out_data.chord_root !== want.chord_root ||
            out_data.is_minor !== want.is_minor ||
            out_data.minor_written !== want.minor_written)
          report_mismatch(1'b0, want, out_data);
      end
    end
  end

  // Directed events: empty mask, note-off, other statuses, field extremes, known triads.
  task automatic test_directed_events();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_event(7'd60, STATUS_NOTE_OFF);   // note-off with nothing held
    send_event(7'd0, 8'd0);               // other status, nothing held
    send_event(7'd0, STATUS_NOTE_ON);     // lone root
    send_event(7'd64, STATUS_NOTE_ON);
    send_event(7'd67, STATUS_NOTE_ON);    // full major triad
    send_event(7'd64, STATUS_NOTE_OFF);
    send_event(7'd63, STATUS_NOTE_ON);    // minor third replaces the major one
    send_event(7'd0, 8'd255);             // release by a non-MIDI status
    send_event(7'd3, 8'd0);
    send_event(7'd7, 8'd143);             // mask empty again, reported as no chord
    send_event(7'd127, STATUS_NOTE_ON);   // top note, negative root
    send_event(7'd66, STATUS_NOTE_ON);    // tie between roots: the earlier one wins
    send_event(7'd127, 8'd145);
    send_event(7'd66, 8'd129);
    send_event(7'd69, STATUS_NOTE_ON);
    send_event(7'd72, STATUS_NOTE_ON);
    send_event(7'd76, STATUS_NOTE_ON);    // minor triad on a negative root
    send_event(7'd71, STATUS_NOTE_ON);
    send_event(7'd69, STATUS_NOTE_OFF);
    send_event(7'd72, STATUS_NOTE_OFF);
    send_event(7'd76, STATUS_NOTE_OFF);
    send_event(7'd71, STATUS_NOTE_OFF);
    send_event(7'd11, STATUS_NOTE_ON);
    send_event(7'd11, 8'h80);
  endtask

  // One random event: mostly note-on and note-off, some arbitrary statuses.
  task automatic send_noise_event();
    int pick;
    logic [7:0] status;
    pick = $urandom_range(99);
    if (pick < 50) status = STATUS_NOTE_ON;
    else if (pick < 80) status = STATUS_NOTE_OFF;
    else status = 8'($urandom_range(255));
    send_event(7'($urandom_range(127)), status);
  endtask

  // A played triad in some octave, an optional passing note, then a release of some or all of its notes.
  task automatic play_triad();
    int base;
    int third;
    int n;
    logic [7:0] rel;
    base  = 12 * $urandom_range(9) + $urandom_range(11);
    third = $urandom_range(1) ? 3 : 4;
    send_event(7'(base), STATUS_NOTE_ON);
    send_event(7'(base + third), STATUS_NOTE_ON);
    send_event(7'(base + 7), STATUS_NOTE_ON);
    if ($urandom_range(2) == 0) send_noise_event();
    for (n = 0; n < 3; n++) begin
      rel = ($urandom_range(3) != 0) ? STATUS_NOTE_OFF : 8'($urandom_range(255));
      if ($urandom_range(4) != 0)
        send_event(7'(base + ((n == 0) ? 0 : (n == 1) ? third : 7)), rel);
    end
    triads_played++;
  endtask

  // Random traffic under three idling patterns.
  task automatic test_random_traffic();
    int set;
    int start;
    for (set = 0; set < 3; set++) begin
      send_idle_pct = (set == 0) ? 21 : (set == 1) ? 67 : 0;
      recv_idle_pct = (set == 0) ? 67 : (set == 1) ? 21 : 0;
      start = events_sent;
      while (events_sent - start < RandomPerSet) begin
        if ($urandom_range(9) < 7) play_triad();
        else send_noise_event();
      end
    end
  endtask

  // Long receiver hold-off while the sender keeps offering, so the input stalls.
  task automatic test_output_hold_off();
    int n;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Withdraw the last offered event before the next rising edge can take it again.
    @(negedge clk);
    in_valid <= 1'b0;
    hold_request = 60;
    for (n = 0; n < 24; n++) send_noise_event();
  endtask

  // Sender pause until the pipeline is empty, then resume with triads.
  task automatic test_drain_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    play_triad();
    wait_for_results();
    play_triad();
    play_triad();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_events();
    test_random_traffic();
    test_output_hold_off();
    test_drain_pause();

    wait_for_results();
    repeat (DrainCycles) @(posedge clk);
    if (chord_expect_q.size() != 0) mismatch_count++;

    $display("Covered %0d events (%0d note-on, %0d note-off, %0d other status, %0d triads)",
             events_sent, note_on_count, note_off_count, other_count, triads_played);
    $display("Checked %0d chord results under random and forced back-pressure, %0d mismatches",
             results_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
